// File: rtl/core/usm_pkg.sv
// ----------------------------------------------------------------------------
// usm_pkg
// Shared widths, codes and CORDIC constants for the UV sphere mesh generator.
// ----------------------------------------------------------------------------
package usm_pkg;

    localparam int STEP_W   = 9;    // step counts, row and column
    localparam int RAD_W    = 16;   // radius, unsigned Q8.8
    localparam int POS_W    = 17;   // position, signed Q8.8
    localparam int NORM_W   = 16;   // normal, signed Q1.14
    localparam int TEX_W    = 16;   // texture, unsigned Q1.15
    localparam int IDX_W    = 17;   // triangle vertex index
    localparam int CFG_W    = 16;   // config data width
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_H  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_V  = 2'd2;

    localparam logic CMD_VERTEX = 1'b0;
    localparam logic CMD_QUAD   = 1'b1;

    localparam int CORDIC_ITERS = 30;
    localparam int CW           = 33;   // CORDIC x/y width, Q2.30 plus headroom
    localparam int ZW           = 32;   // CORDIC residual angle width
    localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 33'sd652032874;

    localparam logic [RAD_W-1:0]  RAD_MIN     = 16'd3;
    localparam logic [STEP_W-1:0] STEPS_H_MIN = 9'd3;
    localparam logic [STEP_W-1:0] STEPS_V_MIN = 9'd2;

    // arctan(2^-k), 2^32 per turn
    function automatic logic signed [ZW-1:0] arc_angle(input int k);
        logic signed [ZW-1:0] a;
        case (k)
            0:  a = 32'sd536870912;
            1:  a = 32'sd316933405;
            2:  a = 32'sd167458907;
            3:  a = 32'sd85004756;
            4:  a = 32'sd42667331;
            5:  a = 32'sd21354465;
            6:  a = 32'sd10679838;
            7:  a = 32'sd5340245;
            8:  a = 32'sd2670163;
            9:  a = 32'sd1335087;
            10: a = 32'sd667544;
            11: a = 32'sd333772;
            12: a = 32'sd166886;
            13: a = 32'sd83443;
            14: a = 32'sd41722;
            15: a = 32'sd20861;
            16: a = 32'sd10430;
            17: a = 32'sd5215;
            18: a = 32'sd2608;
            19: a = 32'sd1304;
            20: a = 32'sd652;
            21: a = 32'sd326;
            22: a = 32'sd163;
            23: a = 32'sd81;
            24: a = 32'sd41;
            25: a = 32'sd20;
            26: a = 32'sd10;
            27: a = 32'sd5;
            28: a = 32'sd3;
            default: a = 32'sd1;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/core/usm_if.sv
// ----------------------------------------------------------------------------
// usm_if
// Valid/ready channels: command words in, mesh result words out.
// ----------------------------------------------------------------------------
interface usm_in_if;
    import usm_pkg::*;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [STEP_W-1:0] row;
    logic [STEP_W-1:0] column;
    modport source (output valid, cmd, row, column, input ready);
    modport sink   (input valid, cmd, row, column, output ready);
endinterface

interface usm_out_if;
    import usm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic [TEX_W-1:0]         tex_u;
    logic [TEX_W-1:0]         tex_v;
    logic [IDX_W-1:0]         tri_first;
    logic [IDX_W-1:0]         tri_second;
    logic [IDX_W-1:0]         tri_third;
    logic                     last;
    modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    tex_u, tex_v, tri_first, tri_second, tri_third, last,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    tex_u, tex_v, tri_first, tri_second, tri_third, last,
                    output ready);
endinterface

// File: rtl/core/uv_sphere_mesh_generator.sv
// ----------------------------------------------------------------------------
// uv_sphere_mesh_generator
// UV sphere tessellator: vertex attributes and quad index triangles.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : command words {cmd, row, column}; cmd 0 asks for one vertex,
//           cmd 1 for the two triangles of the quad at (row, column).
//   o_out : result words; a vertex gives one word, a quad two (last on the
//           second). Unused fields read 0.
//   cfg   : i_cfg_we/i_cfg_idx/i_cfg_data write radius (0), steps around (1)
//           and steps pole to pole (2); write only while the block is idle.
// Pipeline: 1 input stage + (DIVW+1) divider stages + 32 CORDIC stages
//   + 4 multiply/round stages + output register (64 stages at defaults).
// Throughput: one vertex per cycle while the receiver keeps ready high; a quad
//   holds the pipe while its second triangle goes out of the output register.
// Reset: config returns to radius 1.0, 16 x 8 steps; pipeline empties.
// Stall: the whole pipe advances on one enable; when the receiver holds off
//   ready, every stage freezes and no word is lost or repeated.
// ----------------------------------------------------------------------------
module uv_sphere_mesh_generator #(
    parameter int MAX_STEPS  = 256,
    parameter int ANGLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [usm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [usm_pkg::CFG_W-1:0]       i_cfg_data,
    usm_in_if.sink                          i_in,
    usm_out_if.source                       o_out
);
    import usm_pkg::*;

    // divider numerator holds index << (angle bits, one less for latitude, or texture bits) plus rounding
    localparam int TXW  = (ANGLE_BITS > 15) ? ANGLE_BITS : 15;
    localparam int DIVW = STEP_W + TXW;
    localparam int ANG_DEPTH = 32 + 4;             // CORDIC + multiply stages
    localparam int DL   = DIVW + 1 + ANG_DEPTH;    // after the input stage
    localparam int BW   = 19;                      // raw quad base index
    localparam logic [ANGLE_BITS-1:0] QTURN3 = ANGLE_BITS'(3 << (ANGLE_BITS - 2));

    // ---------------- configuration ----------------
    logic [RAD_W-1:0]  r_rad;
    logic [STEP_W-1:0] r_sh_raw;
    logic [STEP_W-1:0] r_sv_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad    <= 16'd256;
            r_sh_raw <= 9'd16;
            r_sv_raw <= 9'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RADIUS:  r_rad    <= i_cfg_data;
                REG_STEPS_H: r_sh_raw <= i_cfg_data[STEP_W-1:0];
                REG_STEPS_V: r_sv_raw <= i_cfg_data[STEP_W-1:0];
                default: ;   // unmapped index ignored
            endcase
        end
    end

    logic [STEP_W-1:0] sh, sv;
    logic [RAD_W-1:0]  rad;

    always_comb begin
        if (r_sh_raw < STEPS_H_MIN)          sh = STEPS_H_MIN;
        else if (int'(r_sh_raw) > MAX_STEPS) sh = STEP_W'(MAX_STEPS);
        else                                 sh = r_sh_raw;
        if (r_sv_raw < STEPS_V_MIN)          sv = STEPS_V_MIN;
        else if (int'(r_sv_raw) > MAX_STEPS) sv = STEP_W'(MAX_STEPS);
        else                                 sv = r_sv_raw;
        rad = (r_rad < RAD_MIN) ? RAD_MIN : r_rad;
    end

    // ---------------- pipeline control ----------------
    logic          r_out_valid, r_quad, r_half;
    logic          en;
    logic          r_s0_valid;
    logic [DL-1:0] r_vld;

    assign en         = !r_out_valid || (o_out.ready && (!r_quad || r_half));
    assign i_in.ready = en;

    // ---------------- input stage: index clamps, quad base ----------------
    logic              r_s0_cmd;
    logic [STEP_W-1:0] r_s0_iv, r_s0_jv;
    logic [BW-1:0]     r_s0_base;
    logic [STEP_W-1:0] iv, jv, iq, jq;

    always_comb begin
        iv = (i_in.row > sv) ? sv : i_in.row;
        jv = (i_in.column > sh) ? sh : i_in.column;
        iq = (i_in.row > sv - 1'b1) ? sv - 1'b1 : i_in.row;
        jq = (i_in.column > sh - 1'b1) ? sh - 1'b1 : i_in.column;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_cmd  <= i_in.cmd;
            r_s0_iv   <= iv;
            r_s0_jv   <= jv;
            r_s0_base <= BW'(iq * ({1'b0, sh} + 10'd1)) + BW'(jq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_vld      <= '0;
        end else if (en) begin
            r_s0_valid <= i_in.valid;
            r_vld      <= {r_vld[DL-2:0], r_s0_valid};
        end
    end

    // ---------------- dividers: phases and texture fractions ----------------
    logic [DIVW-1:0] num_b, num_a, num_tu, num_tv;
    logic [DIVW-1:0] q_b, q_a, q_tu, q_tv;

    assign num_b  = (DIVW'(r_s0_jv) << ANGLE_BITS)       + DIVW'(sh >> 1);
    assign num_a  = (DIVW'(r_s0_iv) << (ANGLE_BITS - 1)) + DIVW'(sv >> 1);
    assign num_tu = (DIVW'(r_s0_jv) << 15)               + DIVW'(sh >> 1);
    assign num_tv = (DIVW'(r_s0_iv) << 15)               + DIVW'(sv >> 1);

    usm_div #(.NW(DIVW)) u_div_b  (.i_clk, .i_en(en), .i_num(num_b),  .i_den(sh), .o_quot(q_b));
    usm_div #(.NW(DIVW)) u_div_a  (.i_clk, .i_en(en), .i_num(num_a),  .i_den(sv), .o_quot(q_a));
    usm_div #(.NW(DIVW)) u_div_tu (.i_clk, .i_en(en), .i_num(num_tu), .i_den(sh), .o_quot(q_tu));
    usm_div #(.NW(DIVW)) u_div_tv (.i_clk, .i_en(en), .i_num(num_tv), .i_den(sv), .o_quot(q_tv));

    // latitude phase is shifted back a quarter turn (three quarters mod one)
    logic [ANGLE_BITS-1:0] ph_a, ph_b;
    assign ph_b = q_b[ANGLE_BITS-1:0];
    assign ph_a = q_a[ANGLE_BITS-1:0] + QTURN3;

    logic signed [CW-1:0] ca, sa, cb, sb;

    usm_cordic u_cordic_a (.i_clk, .i_en(en),
                           .i_phase({ph_a, {(32-ANGLE_BITS){1'b0}}}),
                           .o_cos(ca), .o_sin(sa));
    usm_cordic u_cordic_b (.i_clk, .i_en(en),
                           .i_phase({ph_b, {(32-ANGLE_BITS){1'b0}}}),
                           .o_cos(cb), .o_sin(sb));

    logic [2*TEX_W-1:0] tex_in, tex_out;
    assign tex_in = {TEX_W'(17'd32768 - 17'(q_tu)), q_tv[TEX_W-1:0]};

    usm_pipe #(.W(2*TEX_W), .DEPTH(ANG_DEPTH)) u_tex_pipe (
        .i_clk, .i_en(en), .i_data(tex_in), .o_data(tex_out));

    logic [BW:0] side_out;
    usm_pipe #(.W(BW+1), .DEPTH(DL)) u_side_pipe (
        .i_clk, .i_en(en), .i_data({r_s0_cmd, r_s0_base}), .o_data(side_out));

    // ---------------- multiply and round ----------------
    logic signed [2*CW-1:0] r_pcc, r_pcs;
    logic signed [CW-1:0]   r_m1_sa;
    logic signed [CW-1:0]   r_nx, r_ny, r_nz;
    logic signed [2*CW-1:0] t_cc, t_cs;
    logic signed [CW+RAD_W:0] r_px, r_py, r_pz;
    logic signed [NORM_W-1:0] r_m3_nx, r_m3_ny, r_m3_nz;
    logic signed [POS_W-1:0]  r_m4_px, r_m4_py, r_m4_pz;
    logic signed [NORM_W-1:0] r_m4_nx, r_m4_ny, r_m4_nz;
    logic signed [RAD_W:0]    rad_s;

    assign rad_s = $signed({1'b0, rad});
    assign t_cc  = r_pcc + 66'sd536870912;
    assign t_cs  = r_pcs + 66'sd536870912;

    function automatic logic signed [NORM_W-1:0] norm_q(input logic signed [CW-1:0] n);
        logic signed [CW-1:0] t;
        logic signed [16:0]   v;
        t = n + 33'sd32768;
        v = t[32:16];
        if (v > 17'sd16384)       return 16'sd16384;
        else if (v < -17'sd16384) return -16'sd16384;
        else                      return v[NORM_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] pos_q(input logic signed [CW+RAD_W:0] p);
        logic signed [CW+RAD_W:0]    t;
        logic signed [CW+RAD_W-30:0] v;
        t = p + 50'sd536870912;
        v = $signed(t[CW+RAD_W:30]);
        if (v > 20'sd65535)       return 17'sd65535;
        else if (v < -20'sd65535) return -17'sd65535;
        else                      return v[POS_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            // M1: cos a * cos b, cos a * sin b
            r_pcc   <= ca * cb;
            r_pcs   <= ca * sb;
            r_m1_sa <= sa;
            // M2: back to Q2.30
            r_nx    <= t_cc[CW+29:30];
            r_nz    <= t_cs[CW+29:30];
            r_ny    <= r_m1_sa;
            // M3: scale by radius, normals to Q1.14
            r_px    <= r_nx * rad_s;
            r_py    <= r_ny * rad_s;
            r_pz    <= r_nz * rad_s;
            r_m3_nx <= norm_q(r_nx);
            r_m3_ny <= norm_q(r_ny);
            r_m3_nz <= norm_q(r_nz);
            // M4: positions to Q8.8
            r_m4_px <= pos_q(r_px);
            r_m4_py <= pos_q(r_py);
            r_m4_pz <= pos_q(r_pz);
            r_m4_nx <= r_m3_nx;
            r_m4_ny <= r_m3_ny;
            r_m4_nz <= r_m3_nz;
        end
    end

    // ---------------- output register ----------------
    logic                     end_valid, end_quad;
    logic [BW-1:0]            end_base;
    logic [BW-1:0]            width_ext;
    logic signed [POS_W-1:0]  r_px_o, r_py_o, r_pz_o;
    logic signed [NORM_W-1:0] r_nx_o, r_ny_o, r_nz_o;
    logic [TEX_W-1:0]         r_tu_o, r_tv_o;
    logic [IDX_W-1:0]         r_ta, r_tb, r_tc, r_td;

    assign end_valid = r_vld[DL-1];
    assign end_quad  = side_out[BW];
    assign end_base  = side_out[BW-1:0];
    assign width_ext = BW'(sh) + BW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_quad      <= 1'b0;
            r_half      <= 1'b0;
        end else if (en) begin
            r_out_valid <= end_valid;
            r_quad      <= end_quad;
            r_half      <= 1'b0;
        end else if (o_out.ready) begin
            r_half      <= 1'b1;   // first triangle of a quad taken
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (end_quad == CMD_QUAD) begin
                r_px_o <= '0; r_py_o <= '0; r_pz_o <= '0;
                r_nx_o <= '0; r_ny_o <= '0; r_nz_o <= '0;
                r_tu_o <= '0; r_tv_o <= '0;
            end else begin
                r_px_o <= r_m4_px; r_py_o <= r_m4_py; r_pz_o <= r_m4_pz;
                r_nx_o <= r_m4_nx; r_ny_o <= r_m4_ny; r_nz_o <= r_m4_nz;
                r_tu_o <= tex_out[2*TEX_W-1:TEX_W];
                r_tv_o <= tex_out[TEX_W-1:0];
            end
            r_tb <= end_base[IDX_W-1:0];
            r_ta <= IDX_W'(end_base + BW'(1));
            r_tc <= IDX_W'(end_base + width_ext);
            r_td <= IDX_W'(end_base + width_ext + BW'(1));
        end
    end

    always_comb begin
        o_out.valid  = r_out_valid;
        o_out.pos_x  = r_px_o;
        o_out.pos_y  = r_py_o;
        o_out.pos_z  = r_pz_o;
        o_out.norm_x = r_nx_o;
        o_out.norm_y = r_ny_o;
        o_out.norm_z = r_nz_o;
        o_out.tex_u  = r_tu_o;
        o_out.tex_v  = r_tv_o;
        if (!r_quad) begin
            o_out.tri_first  = '0;
            o_out.tri_second = '0;
            o_out.tri_third  = '0;
            o_out.last       = 1'b1;
        end else if (!r_half) begin
            o_out.tri_first  = r_ta;
            o_out.tri_second = r_tb;
            o_out.tri_third  = r_tc;
            o_out.last       = 1'b0;
        end else begin
            o_out.tri_first  = r_tc;
            o_out.tri_second = r_td;
            o_out.tri_third  = r_ta;
            o_out.last       = 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_quad_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && r_quad && !r_half) |=> (o_out.valid && r_half))
        else $error("quad second triangle missing");
    a_quad_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_quad && !r_half) |-> !i_in.ready)
        else $error("pipe advanced during first triangle");
    a_vertex_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !r_quad) |-> (o_out.last && o_out.tri_first == '0))
        else $error("vertex word malformed");
`endif

endmodule

// File: rtl/core/usm_pipe.sv
// ----------------------------------------------------------------------------
// usm_pipe
// Enabled delay line for side data that rides along the arithmetic stages.
// ----------------------------------------------------------------------------
module usm_pipe #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_data,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_stage [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage[0] <= i_data;
            for (int s = 1; s < DEPTH; s++) begin
                r_stage[s] <= r_stage[s-1];
            end
        end
    end

    assign o_data = r_stage[DEPTH-1];
endmodule

// File: rtl/core/usm_div.sv
// ----------------------------------------------------------------------------
// usm_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module usm_div #(
    parameter int NW = 25
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [NW-1:0]             i_num,
    input  logic [usm_pkg::STEP_W-1:0] i_den,   // static while items are in flight
    output logic [NW-1:0]             o_quot
);
    import usm_pkg::*;

    logic [STEP_W-1:0] r_p [0:NW];   // partial remainder, always below den
    logic [NW-1:0]     r_w [0:NW];   // numerator bits out, quotient bits in

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= '0;
            r_w[0] <= i_num;
        end
    end

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic [STEP_W:0]   t;
        logic              ge;
        logic [STEP_W:0]   diff;
        assign t    = {r_p[s], r_w[s][NW-1]};
        assign ge   = (t >= {1'b0, i_den});
        assign diff = t - {1'b0, i_den};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[s+1] <= ge ? diff[STEP_W-1:0] : t[STEP_W-1:0];
                r_w[s+1] <= {r_w[s][NW-2:0], ge};
            end
        end
    end

    assign o_quot = r_w[NW];
endmodule

// File: rtl/core/usm_cordic.sv
// ----------------------------------------------------------------------------
// usm_cordic
// Pipelined rotation CORDIC: 32-bit phase in, cos/sin in Q2.30 out.
// ----------------------------------------------------------------------------
module usm_cordic (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [31:0]                      i_phase,
    output logic signed [usm_pkg::CW-1:0]    o_cos,
    output logic signed [usm_pkg::CW-1:0]    o_sin
);
    import usm_pkg::*;

    logic signed [CW-1:0] r_x [0:CORDIC_ITERS];
    logic signed [CW-1:0] r_y [0:CORDIC_ITERS];
    logic signed [ZW-1:0] r_z [0:CORDIC_ITERS];
    logic [1:0]           r_q [0:CORDIC_ITERS];
    logic signed [CW-1:0] r_cos;
    logic signed [CW-1:0] r_sin;

    // quadrant fold: rotate only within the first quarter turn
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_GAIN_INV;
            r_y[0] <= '0;
            r_z[0] <= $signed({2'b00, i_phase[29:0]});
            r_q[0] <= i_phase[31:30];
        end
    end

    for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_iter
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        assign dx = r_y[k] >>> k;
        assign dy = r_x[k] >>> k;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k+1] <= r_q[k];
                if (r_z[k] >= 0) begin
                    r_x[k+1] <= r_x[k] - dx;
                    r_y[k+1] <= r_y[k] + dy;
                    r_z[k+1] <= r_z[k] - arc_angle(k);
                end else begin
                    r_x[k+1] <= r_x[k] + dx;
                    r_y[k+1] <= r_y[k] - dy;
                    r_z[k+1] <= r_z[k] + arc_angle(k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[CORDIC_ITERS])
                2'd0: begin
                    r_cos <= r_x[CORDIC_ITERS];
                    r_sin <= r_y[CORDIC_ITERS];
                end
                2'd1: begin
                    r_cos <= -r_y[CORDIC_ITERS];
                    r_sin <= r_x[CORDIC_ITERS];
                end
                2'd2: begin
                    r_cos <= -r_x[CORDIC_ITERS];
                    r_sin <= -r_y[CORDIC_ITERS];
                end
                default: begin
                    r_cos <= r_y[CORDIC_ITERS];
                    r_sin <= -r_x[CORDIC_ITERS];
                end
            endcase
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;
endmodule
